// ----- rtl/rcra_pkg.sv -----
`timescale 1ns / 1ps

package rcra_pkg;

   // Default geometry of the counter grid.
   localparam int GRID_SIDE_DEFAULT  = 128;
   localparam int COUNT_BITS_DEFAULT = 8;

   // Field widths fixed by the interface.
   localparam int FUNC_BITS  = 2;
   localparam int ROW_BITS   = 7;
   localparam int EXT_BITS   = 8;
   localparam int SIDE_BITS  = 8;
   localparam int CELL_BITS  = 8;

   // Coordinates in the back end are one bit wider than a row so that
   // they can reach any side the register can name.
   localparam int COORD_BITS = 8;
   localparam int SPAN_BITS  = 11;            // 5*extent+4
   localparam int INNER_BITS = 2 * EXT_BITS;  // extent squared
   localparam int FAR_BITS   = 2 * SPAN_BITS; // (5*extent+4) squared, 25*d2
   localparam int D2_BITS    = 17;            // squared distance

   localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(128);

   localparam int CMD_QUEUE_DEPTH = 4;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_CROSS = 2'd0,
      FUNC_RING  = 2'd1,
      FUNC_READ  = 2'd2
   } func_code_type;

   typedef enum logic [1:0] {
      CMD_CROSS,
      CMD_RING,
      CMD_READ,
      CMD_READ_ZERO
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [ROW_BITS-1:0]   row;
      logic [ROW_BITS-1:0]   col;
      logic [EXT_BITS-1:0]   extent;
      logic [SIDE_BITS-1:0]  side;
   } cmd_type;

endpackage

// ----- rtl/rcra_ram.sv -----
`timescale 1ns / 1ps

module rcra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rcra_cmd_queue.sv -----
`timescale 1ns / 1ps

module rcra_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rcra_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output rcra_pkg::cmd_type head_cmd
);
   import rcra_pkg::*;

   localparam int PTR_BITS = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type               entries_ff [CMD_QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(CMD_QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/rcra_front.sv -----
`timescale 1ns / 1ps

module rcra_front #(
   parameter int GRID_SIDE = rcra_pkg::GRID_SIDE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rcra_pkg::SIDE_BITS-1:0]   csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rcra_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [rcra_pkg::ROW_BITS-1:0]    req_row,
   input  logic [rcra_pkg::ROW_BITS-1:0]    req_col,
   input  logic [rcra_pkg::EXT_BITS-1:0]    req_extent,
   input  logic                             clearing,
   input  logic                             queue_full,
   output logic                             push,
   output rcra_pkg::cmd_type                push_cmd
);
   import rcra_pkg::*;

   logic [SIDE_BITS-1:0] side_ff, side_in;
   logic [SIDE_BITS-1:0] side_used;
   logic                 in_use;
   logic                 keep;

   assign side_in = csr_wr_en ? csr_wr_data : side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
      end else begin
         side_ff <= side_in;
      end
   end

   // The part in use never reaches past the physical grid.
   assign side_used = (int'(side_ff) > GRID_SIDE) ? SIDE_BITS'(GRID_SIDE) : side_ff;
   assign in_use    = ({1'b0, req_row} < side_used) && ({1'b0, req_col} < side_used);
   assign req_ready = !clearing && !queue_full;

   always_comb begin
      push_cmd.row    = req_row;
      push_cmd.col    = req_col;
      push_cmd.extent = req_extent;
      push_cmd.side   = side_used;
      push_cmd.kind   = CMD_READ_ZERO;
      keep            = 1'b0;
      unique case (req_func)
         FUNC_CROSS: begin
            push_cmd.kind = CMD_CROSS;
            keep          = in_use;
         end
         FUNC_RING: begin
            push_cmd.kind = CMD_RING;
            keep          = in_use;
         end
         FUNC_READ: begin
            // A read off the grid still answers, with a zero count.
            push_cmd.kind = in_use ? CMD_READ : CMD_READ_ZERO;
            keep          = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && req_ready && keep;

endmodule

// ----- rtl/rcra_back.sv -----
`timescale 1ns / 1ps

module rcra_back #(
   parameter int GRID_SIDE  = rcra_pkg::GRID_SIDE_DEFAULT,
   parameter int COUNT_BITS = rcra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  rcra_pkg::cmd_type                head_cmd,
   output logic                             pop,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rcra_pkg::CELL_BITS-1:0]   rsp_cell_count
);
   import rcra_pkg::*;

   localparam int DEPTH      = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_PREP  = 7'b0001000,
      ST_RING  = 7'b0010000,
      ST_CROSS = 7'b0100000,
      ST_DRAIN = 7'b1000000
   } back_state_type;

   typedef enum logic [1:0] {
      ARM_DOWN,
      ARM_RIGHT,
      ARM_UP,
      ARM_LEFT
   } arm_type;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [COORD_BITS-1:0] r,
                                                      input logic [COORD_BITS-1:0] c);
      return ADDR_BITS'(r) * ADDR_BITS'(GRID_SIDE) + ADDR_BITS'(c);
   endfunction

   back_state_type          state_ff, state_in;
   cmd_type                 cur_ff, cur_in;
   logic [COORD_BITS-1:0]   i_ff, i_in;
   logic [COORD_BITS-1:0]   j_ff, j_in;
   arm_type                 arm_ff, arm_in;
   logic [INNER_BITS-1:0]   inner_ff, inner_in;
   logic [FAR_BITS-1:0]     outer_ff, outer_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_BITS-1:0]    rsp_data_ff;

   // Cell candidates and the hit pipeline.
   logic                    cand_valid, cand_force;
   logic [COORD_BITS-1:0]   cand_row, cand_col;
   logic [COORD_BITS-1:0]   cand_di, cand_dj;
   logic                    p1_valid_ff, p1_force_ff;
   logic [ADDR_BITS-1:0]    p1_addr_ff;
   logic [COORD_BITS-1:0]   p1_di_ff, p1_dj_ff;
   logic                    p2_valid_ff, p2_force_ff;
   logic [ADDR_BITS-1:0]    p2_addr_ff;
   logic [D2_BITS-1:0]      p2_d2_ff;
   logic                    p2_hit;
   logic [FAR_BITS-1:0]     p2_far;
   logic                    p3_valid_ff;
   logic [ADDR_BITS-1:0]    p3_addr_ff;

   // Walker temporaries.
   logic [COORD_BITS-1:0]   cur_row, cur_col, last_idx;
   logic [COORD_BITS:0]     arm_sum;
   logic                    arm_ok, cross_emit;
   logic [SPAN_BITS-1:0]    span;

   // Memory port signals.
   logic                    idle_read, rsp_load;
   logic                    ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0]    ram_wr_addr, ram_rd_addr;
   logic [COUNT_BITS-1:0]   ram_wr_data, ram_rd_data;

   assign cur_row  = {1'b0, cur_ff.row};
   assign cur_col  = {1'b0, cur_ff.col};
   assign last_idx = cur_ff.side - 1'b1;
   assign span     = (SPAN_BITS'(cur_ff.extent) << 2) + SPAN_BITS'(cur_ff.extent) + SPAN_BITS'(4);

   // One arm step of a cross: where it lands and whether it stays in use.
   always_comb begin
      arm_sum = '0;
      arm_ok  = 1'b0;
      unique case (arm_ff)
         ARM_DOWN: begin
            arm_sum = {1'b0, cur_row} + {1'b0, i_ff};
            arm_ok  = arm_sum < {1'b0, cur_ff.side};
         end
         ARM_RIGHT: begin
            arm_sum = {1'b0, cur_col} + {1'b0, i_ff};
            arm_ok  = arm_sum < {1'b0, cur_ff.side};
         end
         ARM_UP: begin
            arm_sum = {1'b0, cur_row - i_ff};
            arm_ok  = i_ff <= cur_row;
         end
         ARM_LEFT: begin
            arm_sum = {1'b0, cur_col - i_ff};
            arm_ok  = i_ff <= cur_col;
         end
         default: begin
            arm_ok = 1'b0;
         end
      endcase
   end

   // Step zero of the first arm is the centre, which always counts.
   assign cross_emit = (i_ff == '0) || ((i_ff < cur_ff.extent) && arm_ok);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      arm_in     = arm_ff;
      inner_in   = inner_ff;
      outer_in   = outer_ff;
      clr_in     = clr_ff;
      cand_valid = 1'b0;
      cand_force = 1'b0;
      cand_row   = cur_row;
      cand_col   = cur_col;
      pop        = 1'b0;
      idle_read  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head_cmd;
               i_in   = '0;
               j_in   = '0;
               arm_in = ARM_DOWN;
               unique case (head_cmd.kind)
                  CMD_CROSS: state_in = ST_CROSS;
                  CMD_RING:  state_in = ST_PREP;
                  CMD_READ: begin
                     idle_read = 1'b1;
                     state_in  = ST_READ;
                  end
                  CMD_READ_ZERO: state_in = ST_READ;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PREP: begin
            inner_in   = INNER_BITS'(cur_ff.extent) * INNER_BITS'(cur_ff.extent);
            outer_in   = FAR_BITS'(span) * FAR_BITS'(span);
            cand_valid = 1'b1;
            cand_force = 1'b1;
            state_in   = ST_RING;
         end
         ST_RING: begin
            cand_valid = 1'b1;
            cand_row   = i_ff;
            cand_col   = j_ff;
            if (j_ff == last_idx) begin
               j_in = '0;
               if (i_ff == last_idx) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_CROSS: begin
            if (cross_emit) begin
               cand_valid = 1'b1;
               cand_force = 1'b1;
               if (arm_ff == ARM_DOWN || arm_ff == ARM_UP) begin
                  cand_row = arm_sum[COORD_BITS-1:0];
               end else begin
                  cand_col = arm_sum[COORD_BITS-1:0];
               end
               i_in = i_ff + 1'b1;
            end else begin
               i_in = COORD_BITS'(1);
               unique case (arm_ff)
                  ARM_DOWN:  arm_in = ARM_RIGHT;
                  ARM_RIGHT: arm_in = ARM_UP;
                  ARM_UP:    arm_in = ARM_LEFT;
                  ARM_LEFT:  state_in = ST_DRAIN;
                  default:   state_in = ST_DRAIN;
               endcase
            end
         end
         ST_DRAIN: begin
            // The next item may touch the same cells, so the pipeline empties first.
            if (!p1_valid_ff && !p2_valid_ff && !p3_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cand_di = (cand_row >= cur_row) ? cand_row - cur_row : cur_row - cand_row;
   assign cand_dj = (cand_col >= cur_col) ? cand_col - cur_col : cur_col - cand_col;

   // 25*d2 by shift and add.
   assign p2_far = (FAR_BITS'(p2_d2_ff) << 4) + (FAR_BITS'(p2_d2_ff) << 3) + FAR_BITS'(p2_d2_ff);
   assign p2_hit = p2_valid_ff &&
                   (p2_force_ff || ((p2_d2_ff > D2_BITS'(inner_ff)) && (p2_far < outer_ff)));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         arm_ff       <= ARM_DOWN;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= cand_valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_hit;
         arm_ff       <= arm_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      inner_ff    <= inner_in;
      outer_ff    <= outer_in;
      p1_force_ff <= cand_force;
      p1_addr_ff  <= cell_addr(cand_row, cand_col);
      p1_di_ff    <= cand_di;
      p1_dj_ff    <= cand_dj;
      p2_force_ff <= p1_force_ff;
      p2_addr_ff  <= p1_addr_ff;
      p2_d2_ff    <= D2_BITS'(p1_di_ff) * D2_BITS'(p1_di_ff)
                   + D2_BITS'(p1_dj_ff) * D2_BITS'(p1_dj_ff);
      p3_addr_ff  <= p2_addr_ff;
      if (rsp_load) begin
         rsp_data_ff <= (cur_ff.kind == CMD_READ_ZERO) ? '0 : CELL_BITS'(ram_rd_data);
      end
   end

   assign ram_rd_en   = p2_hit || idle_read;
   assign ram_rd_addr = idle_read ? cell_addr({1'b0, head_cmd.row}, {1'b0, head_cmd.col})
                                  : p2_addr_ff;
   assign clearing    = (state_ff == ST_CLEAR);
   assign ram_wr_en   = clearing || p3_valid_ff;
   assign ram_wr_addr = clearing ? clr_ff : p3_addr_ff;
   assign ram_wr_data = clearing ? '0
                      : ((ram_rd_data == COUNT_MAX) ? ram_rd_data : ram_rd_data + 1'b1);

   rcra_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_count = rsp_data_ff;

endmodule

// ----- rtl/raster_cross_ring_accumulator_unit.sv -----
`timescale 1ns / 1ps

// Grid of saturating hit counters that draws crosses and rings and reads cells.
// Items arrive as beats on the req_ channel (valid/ready); only reads produce a
// beat on the rsp_ channel, carrying the low 8 bits of the cell's count. The
// csr_ port writes the side of the grid in use; the user must write it only
// while the block is idle. The block itself does not enforce this.
// The front end checks each beat against the side in use and queues reads and
// the draws that fall inside it; the back end works one item at a time against
// a single grid memory that has one read and one write port. With the back end
// idle, a read passes through the queue, the memory's read register and the
// output register before it answers. A cross walks its counted cells arm by
// arm, and a ring scans every cell in use, one per cycle. The queue takes up to
// four items while the back end is busy.
// After reset the memory is zeroed one cell per cycle, all GRID_SIDE*GRID_SIDE
// cells, with req_ready low throughout; the csr_ port is live at once.
// A stalled response holds in its output register; the back end stops only
// at the next read, and the front end keeps taking beats until the queue fills.
module raster_cross_ring_accumulator_unit #(
   parameter int GRID_SIDE  = rcra_pkg::GRID_SIDE_DEFAULT,
   parameter int COUNT_BITS = rcra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rcra_pkg::SIDE_BITS-1:0]   csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rcra_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [rcra_pkg::ROW_BITS-1:0]    req_row,
   input  logic [rcra_pkg::ROW_BITS-1:0]    req_col,
   input  logic [rcra_pkg::EXT_BITS-1:0]    req_extent,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rcra_pkg::CELL_BITS-1:0]   rsp_cell_count
);
   import rcra_pkg::*;

   logic    clearing;
   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // Classifies beats and drops draws that fall off the grid in use.
   rcra_front #(
      .GRID_SIDE (GRID_SIDE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_extent  (req_extent),
      .clearing    (clearing),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   rcra_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Walks the cells of each item and updates the grid memory.
   rcra_back #(
      .GRID_SIDE  (GRID_SIDE),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_count (rsp_cell_count)
   );

endmodule

// ----- rtl/rcra_checker.sv -----
`timescale 1ns / 1ps

module rcra_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rcra_pkg::CELL_BITS-1:0]   rsp_cell_count
);

   // Leaving reset, the grid is being zeroed and nothing is pending.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_ready && !rsp_valid))
      else $error("block not quiet right after reset");

   // Outside reset, the front end only stops taking beats when a beat fills the queue.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(req_ready) && !$past(reset)) |-> $past(req_valid && req_ready))
      else $error("req_ready fell without an accepted beat");

   // A stalled response beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cell_count)))
      else $error("stalled response beat dropped or changed");

endmodule

bind raster_cross_ring_accumulator_unit rcra_checker u_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the cross/ring hit-counter grid.
//
// The bench keeps a shadow copy of the counter grid and of the side register.
// Every beat that the block accepts on the req_ channel is applied to that
// shadow at the same clock edge. A read beat queues the count it must return.
// Each beat on the rsp_ channel is then compared with the oldest queued count.
//
// Stimulus comes in two parts. A short directed plan walks the edges:
//    - reads of a freshly cleared grid
//    - extreme extents and corner centres
//    - the ignored function code
//    - a side register above the grid size, and a side of zero
//    - centres outside the part in use
// Random phases follow. Each phase picks a new side and mixes draws with reads.
// Reads often return to the centre of the last draw, so that they see non-zero
// counts.
//
// The side register is only written once the block has gone quiet. First every
// queued count must have come back. Then the bench waits out an estimate of the
// draws that may still be running behind the last read.
module tb_top;
   import rcra_pkg::*;

   localparam int GRID        = GRID_SIDE_DEFAULT;
   localparam int COUNT_TOP   = (1 << COUNT_BITS_DEFAULT) - 1;
   localparam int RAND_ITEMS  = 75;
   localparam int LONG_HOLD   = 3000;
   // Five full-size rings back to back (one running and four queued), plus the
   // clearing pass after reset, stay well inside this limit.
   localparam int STALL_LIMIT = 250000;
   localparam int TAIL_CAP    = 100000;

   // The package enum leaves code three out; the block must ignore it.
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

   typedef enum {RSP_EAGER, RSP_COIN, RSP_SPARSE, RSP_PULSED} rsp_mode_type;

   typedef struct {
      int                   side;
      logic [FUNC_BITS-1:0] func;
      int                   row;
      int                   col;
      int                   extent;
      int                   repeats;
      bit                   pinned;
      int                   count;
   } drill_step_type;

   localparam int DRILL_STEPS = 26;

   // Columns: side register, function, row, column, extent, repeat count, and
   // whether the returned count is fixed here (with that count). A row whose
   // count is not fixed is checked against the shadow grid.
   drill_step_type drill_plan [DRILL_STEPS] = '{
      // A freshly cleared grid reads zero, even in the far corner.
      '{128, FUNC_READ,     0,   0,   0,   1, 1,   0},
      '{128, FUNC_READ,   127, 127, 255,   1, 1,   0},
      // An extent of zero or one counts the centre only.
      '{128, FUNC_CROSS,   64,  64,   0,   1, 0,   0},
      '{128, FUNC_READ,    64,  64,   0,   1, 0,   0},
      '{128, FUNC_CROSS,    0,   0,   1,   1, 0,   0},
      // The longest arms, clipped on two sides at the far corner.
      '{128, FUNC_CROSS,  127, 127, 255,   1, 0,   0},
      '{128, FUNC_READ,   127,   0,   0,   1, 0,   0},
      // One ring over the full grid.
      '{128, FUNC_RING,    64,  64,   3,   1, 0,   0},
      '{128, FUNC_READ,    64,  67,   0,   1, 0,   0},
      // The unused code must leave no trace and return nothing.
      '{128, FUNC_UNUSED,   5,   5,   7,   1, 0,   0},
      '{128, FUNC_READ,     5,   5,   0,   1, 1,   0},
      // A side above the grid size is clipped to the grid.
      '{255, FUNC_CROSS,  127,   0, 200,   1, 0,   0},
      '{255, FUNC_READ,   127,   0,   0,   1, 0,   0},
      // With a side of zero, draws do nothing and reads return zero.
      '{0,   FUNC_CROSS,    0,   0,   5,   1, 0,   0},
      '{0,   FUNC_RING,     0,   0,   2,   1, 0,   0},
      '{0,   FUNC_READ,     0,   0,   0,   1, 1,   0},
      // A cell just outside the part in use reads zero and cannot be drawn on.
      '{4,   FUNC_READ,     4,   0,   0,   1, 1,   0},
      '{4,   FUNC_CROSS,    4,   4,   3,   1, 0,   0},
      '{4,   FUNC_CROSS,    1,   1,   3,   1, 0,   0},
      '{4,   FUNC_RING,     1,   2,   1,   1, 0,   0},
      '{4,   FUNC_RING,     0,   0, 255,   1, 0,   0},
      // A few back-to-back hits on one cell of the small square.
      '{4,   FUNC_CROSS,    2,   2,   1,   3, 0,   0},
      '{4,   FUNC_READ,     2,   2,   0,   1, 0,   0},
      // Back at full size, cells beyond the small square kept their counts.
      '{128, FUNC_READ,     1,   4,   0,   1, 0,   0},
      '{128, FUNC_READ,   127,   5,   0,   1, 0,   0},
      '{128, FUNC_READ,    64,  64,   0,   1, 0,   0}
   };

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [SIDE_BITS-1:0] csr_wr_data = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [FUNC_BITS-1:0] req_func    = FUNC_CROSS;
   logic [ROW_BITS-1:0]  req_row     = '0;
   logic [ROW_BITS-1:0]  req_col     = '0;
   logic [EXT_BITS-1:0]  req_extent  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [CELL_BITS-1:0] rsp_cell_count;

   // Shadow state of the block.
   logic [COUNT_BITS_DEFAULT-1:0] shadow_hits [GRID][GRID];
   logic [SIDE_BITS-1:0]          shadow_side = SIDE_RESET;

   // Counts that the block still owes on the rsp_ channel, oldest first.
   logic [CELL_BITS-1:0] counts_due [$];

   // A rough estimate of the cycles that the block needs for the draws it took
   // after the last read. It lets the bench know how long to wait before the
   // register may change.
   int draw_backlog = 0;

   int  req_beats   = 0;
   int  fault_count = 0;
   int  burst_left  = 0;
   bit  pinned_valid = 1'b0;
   int  pinned_count = 0;
   bit  long_hold_wanted = 1'b0;

   raster_cross_ring_accumulator_unit dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_extent    (req_extent),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_count(rsp_cell_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow grid
   // ---------------------------------------------------------------------

   // The part of the grid in use. Register values above the grid size are
   // clipped to the grid.
   function automatic int sides_live();
      return (shadow_side > GRID) ? GRID : int'(shadow_side);
   endfunction

   // Counters saturate at the top count.
   function automatic void tally(int r, int c);
      if (r < GRID && c < GRID && shadow_hits[r][c] != COUNT_TOP) begin
         shadow_hits[r][c] = shadow_hits[r][c] + 1'b1;
      end
   endfunction

   // The centre cell, then each of the four arms, clipped at the edge of the
   // part in use.
   function automatic void tally_cross(int r, int c, int arm, int s);
      int i;
      tally(r, c);
      for (i = 1; i < arm && r + i < s; i++) tally(r + i, c);
      for (i = 1; i < arm && c + i < s; i++) tally(r, c + i);
      for (i = 1; i < arm && i <= r; i++) tally(r - i, c);
      for (i = 1; i < arm && i <= c; i++) tally(r, c - i);
   endfunction

   // The ring is the band from rad to rad + 0.8, in integer form. A cell lies
   // on the ring when d2 > rad^2 and 25*d2 < (5*rad + 4)^2. The centre cell is
   // counted as well, on its own.
   function automatic void tally_ring(int r, int c, int rad, int s);
      longint inner, outer, d2, di, dj;
      int i, j;
      inner = longint'(rad) * rad;
      outer = (longint'(5) * rad + 4) * (longint'(5) * rad + 4);
      tally(r, c);
      for (i = 0; i < s; i++) begin
         di = i - r;
         for (j = 0; j < s; j++) begin
            dj = j - c;
            d2 = di * di + dj * dj;
            if (d2 > inner && 25 * d2 < outer) tally(i, j);
         end
      end
   endfunction

   // Applies one accepted beat to the shadow grid. A read queues the count
   // that the block must return for it.
   function automatic void absorb_beat(logic [FUNC_BITS-1:0] f, int r, int c, int e);
      int s;
      bit on_grid;
      logic [CELL_BITS-1:0] owed;
      s = sides_live();
      on_grid = (r < s) && (c < s);
      case (f)
         FUNC_CROSS: begin
            if (on_grid) tally_cross(r, c, e, s);
            draw_backlog += 4 * e + 16;
         end
         FUNC_RING: begin
            if (on_grid) tally_ring(r, c, e, s);
            draw_backlog += s * s + 16;
         end
         FUNC_READ: begin
            owed = on_grid ? CELL_BITS'(shadow_hits[r][c]) : '0;
            if (pinned_valid) owed = CELL_BITS'(pinned_count);
            counts_due.push_back(owed);
            // Everything taken before this read is finished by the time its
            // count comes back.
            draw_backlog = 0;
         end
         default: begin
            draw_backlog += 16;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s (got %0d, want %0d)", $realtime, what, got, want);
      fault_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: both channels and the register port, sampled at the rising edge
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_hits[i, j]) shadow_hits[i][j] = '0;
         shadow_side = SIDE_RESET;
      end else begin
         // Check the result beat first. A read accepted at this same edge
         // cannot have produced it.
         if (rsp_valid && rsp_ready) begin
            if (counts_due.size() == 0) begin
               report_mismatch("result beat with no read outstanding",
                               int'(rsp_cell_count), -1);
            end else if (rsp_cell_count !== counts_due[0]) begin
               report_mismatch("cell_count", int'(rsp_cell_count), int'(counts_due[0]));
               void'(counts_due.pop_front());
            end else begin
               void'(counts_due.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            absorb_beat(req_func, int'(req_row), int'(req_col), int'(req_extent));
            req_beats <= req_beats + 1;
         end
         if (csr_wr_en) shadow_side = csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stalls on a pattern of its own, with one long hold on request
   // ---------------------------------------------------------------------

   initial begin : rsp_side
      rsp_mode_type mode;
      int           mode_left;
      int           hold_left;
      mode      = RSP_EAGER;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_wanted) begin
            // The hold outlasts the queue by far, so the block stalls its input.
            long_hold_wanted = 1'b0;
            hold_left        = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rsp_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RSP_EAGER:  rsp_ready <= 1'b1;
               RSP_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RSP_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_ready <= ((mode_left % 8) < 3);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: counts cycles in which something is waiting but nothing moves
   // ---------------------------------------------------------------------

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else if (req_valid || counts_due.size() != 0) begin
            idle_cycles++;
         end else begin
            idle_cycles = 0;
         end
      end
      $display("TIMEOUT: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Offers one beat and returns at the falling edge after it was taken.
   // The sender works in bursts. Between bursts it drops valid for a random
   // gap. Valid is set at most once per step, so a beat that directly follows
   // another keeps valid high without a glitch. The caller must offer the next
   // beat at once, or call settle_grid, which drops valid.
   task automatic offer_beat(input logic [FUNC_BITS-1:0] f, input int r, input int c,
                             input int e, input bit pin, input int pin_count);
      int seen;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
            @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_valid  <= 1'b1;
      req_func   <= f;
      req_row    <= ROW_BITS'(r);
      req_col    <= ROW_BITS'(c);
      req_extent <= EXT_BITS'(e);
      pinned_valid = pin;
      pinned_count = pin_count;
      seen = req_beats;
      do @(negedge clock); while (req_beats == seen);
      burst_left--;
   endtask

   // Drains the block. First every owed count must have come back. Then the
   // bench waits out the draws that may still run behind the last read.
   task automatic settle_grid();
      int tail;
      req_valid <= 1'b0;
      do @(negedge clock); while (counts_due.size() != 0);
      tail = draw_backlog + draw_backlog / 4 + 64;
      if (tail > TAIL_CAP) tail = TAIL_CAP;
      repeat (tail) @(negedge clock);
      draw_backlog = 0;
   endtask

   task automatic write_side(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SIDE_BITS'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int                   step, phase, n, k, counted, pick;
      int                   side_now, side_pick, s, r, c, e;
      int                   last_row, last_col;
      logic [FUNC_BITS-1:0] f;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      side_now = int'(SIDE_RESET);

      // Directed plan. The block is still clearing its memory after reset, so
      // the first beat waits on req_ready for a while.
      for (step = 0; step < DRILL_STEPS; step++) begin
         if (drill_plan[step].side != side_now) begin
            settle_grid();
            write_side(drill_plan[step].side);
            side_now = drill_plan[step].side;
         end
         repeat (drill_plan[step].repeats) begin
            offer_beat(drill_plan[step].func, drill_plan[step].row, drill_plan[step].col,
                       drill_plan[step].extent, drill_plan[step].pinned,
                       drill_plan[step].count);
         end
      end

      // Random phases. Each starts from a drained block with a fresh side.
      // Most sides are small, so that rings, which scan the whole part in use,
      // stay cheap. A few phases run at full size with rare rings.
      counted  = 0;
      phase    = 0;
      last_row = 0;
      last_col = 0;
      while (counted < RAND_ITEMS) begin
         settle_grid();
         if (phase == 1) begin
            side_pick = $urandom_range(2, 16);
         end else begin
            case ($urandom_range(0, 9))
               0:       side_pick = 0;
               1:       side_pick = 1;
               2:       side_pick = $urandom_range(129, 255);
               3:       side_pick = $urandom_range(33, 128);
               default: side_pick = $urandom_range(2, 32);
            endcase
         end
         write_side(side_pick);
         s = (side_pick > GRID) ? GRID : side_pick;

         // In the second phase the receiver holds off for a long stretch.
         // The phase opens with reads, so the output register and the queue
         // both fill and the block stops taking beats.
         if (phase == 1) long_hold_wanted = 1'b1;

         n = $urandom_range(8, 16);
         for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) f = FUNC_CROSS;
            else if (pick < 55) f = FUNC_RING;
            else if (pick < 94) f = FUNC_READ;
            else f = FUNC_UNUSED;
            if (f == FUNC_RING && s > 32 && $urandom_range(0, 15) != 0) f = FUNC_CROSS;
            if (phase == 1 && k < 8) f = FUNC_READ;

            if (s > 0 && $urandom_range(0, 9) != 0) begin
               r = $urandom_range(0, s - 1);
               c = $urandom_range(0, s - 1);
            end else begin
               r = $urandom_range(0, 127);
               c = $urandom_range(0, 127);
            end
            if (f == FUNC_READ && $urandom_range(0, 2) == 0) begin
               r = last_row;
               c = last_col;
            end
            if ($urandom_range(0, 3) == 0) begin
               e = $urandom_range(0, 255);
            end else begin
               e = $urandom_range(0, (s + 2 > 255) ? 255 : s + 2);
            end
            if (f == FUNC_CROSS || f == FUNC_RING) begin
               last_row = r;
               last_col = c;
            end

            offer_beat(f, r, c, e, 1'b0, 0);
            counted++;
         end
         phase++;
      end

      settle_grid();
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- raster_cross_ring_accumulator_unit.f -----
rtl/rcra_pkg.sv
rtl/rcra_ram.sv
rtl/rcra_cmd_queue.sv
rtl/rcra_front.sv
rtl/rcra_back.sv
rtl/raster_cross_ring_accumulator_unit.sv
rtl/rcra_checker.sv
tb/tb_top.sv
